// ===== hdl/stx_etx_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// stx/etx frame receiver assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_RECEIVER_ASSERT_SVH
`define STX_ETX_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define SEFR_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sefr same-cycle check failed");

`define SEFR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sefr next-cycle check failed");

`else

`define SEFR_ASSERT_SAME(name, ante, cons)

`define SEFR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hdl/sefr_pkg.sv =====
// ----------------------------------------------------------------------------
// sefr_pkg
// types and constants shared by the stx/etx frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package sefr_pkg;

    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_OPEN    = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_RECEIVE  = 2'd1;
    localparam logic [1:0] ERR_LENGTH   = 2'd2;
    localparam logic [1:0] ERR_CHECKSUM = 2'd3;

    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // lengths are compared on nine bits, enough for a full 256 byte half
    localparam int          CMP_W            = 9;
    localparam logic [8:0]  ERROR_CLEAR_FROM = 9'd12;
    localparam logic [8:0]  FRAME_OVERHEAD   = 9'd5;
    localparam logic [8:0]  MAX_STORED       = 9'd255;
    localparam logic [8:0]  ID_POS           = 9'd2;
    localparam logic [8:0]  PAYLOAD_POS      = 9'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } item_t;

    typedef struct packed {
        logic       frame_written;
        logic       frame_ready;
        logic       frame_ok;
        logic [1:0] error_code;
        logic [7:0] frame_id;
        logic [7:0] payload_length;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic       frame_written;
        logic       frame_ready;
        logic       frame_ok;
        logic [1:0] error_code;
        logic [7:0] payload_length;
        logic       use_id;
        logic       use_data;
    } stage_t;

endpackage

`default_nettype wire

// ===== hdl/sefr_store.sv =====
// ----------------------------------------------------------------------------
// sefr_store
// byte-wide frame store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sefr_store #(
    parameter int ADDR_W = 9
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [2**ADDR_W];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/stx_etx_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver
// stx/etx framed byte receiver with a double-buffered frame store
// ----------------------------------------------------------------------------
// One transfer is taken every clock cycle while the output is not stalled,
// received bytes and reader commands alike; its result passes the frame
// store read stage and then the output register. The frame store takes
// one byte write or one byte read per transfer. Frame control and the
// per-half length, error, checksum and claimed length live in flip-flops
// and are updated in the cycle of the transfer, so the next transfer sees
// them at once. The store needs no clearing after reset.
`default_nettype none
`include "stx_etx_frame_receiver_assert.svh"

module stx_etx_frame_receiver
    import sefr_pkg::*;
#(
    parameter int FRAME_DEPTH = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    localparam int POS_W  = $clog2(FRAME_DEPTH);
    localparam int LEN_W  = $clog2(FRAME_DEPTH + 1);
    localparam int ADDR_W = POS_W + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(FRAME_DEPTH);

    logic write_started_reg, write_started_next;
    logic write_finished_reg, write_finished_next;
    logic read_started_reg, read_started_next;
    logic read_finished_reg, read_finished_next;
    logic writer_half_reg, writer_half_next;

    logic [LEN_W-1:0] length_reg [2];
    logic [LEN_W-1:0] length_next [2];
    logic             error_reg [2];
    logic             error_next [2];
    logic [7:0]       xor_reg [2];
    logic [7:0]       xor_next [2];
    logic [7:0]       claimed_reg [2];
    logic [7:0]       claimed_next [2];
    logic [7:0]       last_reg [2];
    logic [7:0]       last_next [2];

    logic    stage_valid_reg, stage_valid_next;
    stage_t  stage_reg, stage_next;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic              accept;
    logic              stage_move;
    logic              restart;
    logic              restart_swap;
    logic              h1;
    logic              ws1, wf1, rs1, rf1;
    logic [LEN_W-1:0]  len1;
    logic              err1;
    logic [7:0]        xor1;
    logic              end_swap;
    logic              end_write;
    logic              rh;
    logic [CMP_W-1:0]  size_c;
    logic [CMP_W-1:0]  claimed_c;
    logic [CMP_W-1:0]  stored_c;
    logic [CMP_W-1:0]  read_pos;
    logic              overflow;
    logic              over_length;
    logic              frame_done;
    logic [1:0]        code;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    sefr_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (item.rx_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign stage_move = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || stage_move;
    assign accept     = item_valid && item_ready;

    // stx start of frame, with a swap attempt first
    assign restart      = accept && (item.mode == MODE_BYTE) && (item.rx_byte == STX_BYTE)
                          && (!write_started_reg || write_finished_reg);
    assign restart_swap = restart && (read_finished_reg || !read_started_reg)
                          && write_finished_reg;
    assign h1   = writer_half_reg ^ restart_swap;
    assign ws1  = restart || write_started_reg;
    assign wf1  = restart ? 1'b0 : write_finished_reg;
    assign rs1  = restart_swap ? 1'b0 : read_started_reg;
    assign rf1  = restart_swap ? 1'b0 : read_finished_reg;
    assign len1 = restart ? '0 : length_reg[h1];
    assign err1 = restart ? 1'b0 : error_reg[h1];
    assign xor1 = restart ? 8'h00 : xor_reg[h1];
    assign end_swap = rf1 || !rs1;

    assign size_c      = CMP_W'(len1);
    assign claimed_c   = (size_c >= 9'd2) ? {1'b0, claimed_reg[h1]} : '0;
    assign overflow    = size_c >= DEPTH_C;
    assign over_length = (claimed_c != '0) && (size_c >= claimed_c);
    assign frame_done  = (size_c >= 9'd2) && (last_reg[h1] == ETX_BYTE)
                         && ((size_c + 9'd1) == claimed_c);

    assign rh       = ~writer_half_reg;
    assign stored_c = CMP_W'(length_reg[rh]);
    assign read_pos = {1'b0, item.read_index} + PAYLOAD_POS;

    always_comb
    begin
        if (error_reg[rh])
        begin
            code = ERR_RECEIVE;
        end
        else if (stored_c < FRAME_OVERHEAD || stored_c > MAX_STORED
                 || stored_c != {1'b0, claimed_reg[rh]})
        begin
            code = ERR_LENGTH;
        end
        else if (xor_reg[rh] != 8'h00)
        begin
            code = ERR_CHECKSUM;
        end
        else
        begin
            code = ERR_NONE;
        end
    end

    always_comb
    begin
        write_started_next  = write_started_reg;
        write_finished_next = write_finished_reg;
        read_started_next   = read_started_reg;
        read_finished_next  = read_finished_reg;
        writer_half_next    = writer_half_reg;
        length_next         = length_reg;
        error_next          = error_reg;
        xor_next            = xor_reg;
        claimed_next        = claimed_reg;
        last_next           = last_reg;
        end_write           = 1'b0;
        mem_we              = 1'b0;
        mem_waddr           = {h1, len1[POS_W-1:0]};
        mem_re              = 1'b0;
        mem_raddr           = {rh, ID_POS[POS_W-1:0]};
        stage_next          = '0;

        if (accept)
        begin
            unique case (item.mode)
                MODE_BYTE:
                begin
                    write_started_next  = ws1;
                    write_finished_next = wf1;
                    read_started_next   = rs1;
                    read_finished_next  = rf1;
                    writer_half_next    = h1;
                    length_next[h1]     = len1;
                    error_next[h1]      = err1;
                    xor_next[h1]        = xor1;
                    if (ws1 && wf1)
                    begin
                        end_write = 1'b1;
                    end
                    else if (ws1)
                    begin
                        if (overflow || over_length)
                        begin
                            length_next[h1]          = '0;
                            error_next[h1]           = 1'b1;
                            end_write                = 1'b1;
                            stage_next.frame_written = 1'b1;
                        end
                        else
                        begin
                            if (size_c >= ERROR_CLEAR_FROM)
                            begin
                                error_next[h1] = 1'b0;
                            end
                            mem_we = 1'b1;
                            if (size_c == 9'd1)
                            begin
                                claimed_next[h1] = item.rx_byte;
                            end
                            xor_next[h1]    = xor1 ^ item.rx_byte;
                            length_next[h1] = LEN_W'(size_c + 9'd1);
                            last_next[h1]   = item.rx_byte;
                            if (frame_done)
                            begin
                                end_write                = 1'b1;
                                stage_next.frame_written = 1'b1;
                            end
                        end
                    end
                    if (end_write)
                    begin
                        write_finished_next = 1'b1;
                        if (end_swap)
                        begin
                            write_started_next  = 1'b0;
                            write_finished_next = 1'b0;
                            read_started_next   = 1'b0;
                            read_finished_next  = 1'b0;
                            writer_half_next    = ~h1;
                        end
                    end
                end
                MODE_OPEN:
                begin
                    if (!read_finished_reg)
                    begin
                        read_started_next         = 1'b1;
                        read_finished_next        = (code != ERR_NONE);
                        stage_next.frame_ready    = 1'b1;
                        stage_next.frame_ok       = (code == ERR_NONE);
                        stage_next.error_code     = code;
                        stage_next.payload_length = 8'(stored_c - FRAME_OVERHEAD);
                        stage_next.use_id         = 1'b1;
                        mem_re                    = 1'b1;
                    end
                end
                MODE_READ:
                begin
                    if (read_pos < DEPTH_C)
                    begin
                        stage_next.use_data = 1'b1;
                        mem_re              = 1'b1;
                        mem_raddr           = {rh, read_pos[POS_W-1:0]};
                    end
                end
                MODE_RELEASE:
                begin
                    read_finished_next = 1'b1;
                end
                default:
                begin
                    read_finished_next = read_finished_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        result_next                = '0;
        result_next.frame_written  = stage_reg.frame_written;
        result_next.frame_ready    = stage_reg.frame_ready;
        result_next.frame_ok       = stage_reg.frame_ok;
        result_next.error_code     = stage_reg.error_code;
        result_next.payload_length = stage_reg.payload_length;
        result_next.frame_id       = stage_reg.use_id ? mem_rdata : 8'h00;
        result_next.read_data      = stage_reg.use_data ? mem_rdata : 8'h00;
    end

    always_comb
    begin
        priority if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_move)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end

        priority if (stage_move)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_started_reg  <= 1'b0;
            write_finished_reg <= 1'b0;
            read_started_reg   <= 1'b1;
            read_finished_reg  <= 1'b1;
            writer_half_reg    <= 1'b0;
            length_reg         <= '{default: '0};
            error_reg          <= '{default: 1'b0};
            xor_reg            <= '{default: 8'h00};
            claimed_reg        <= '{default: 8'h00};
            last_reg           <= '{default: 8'h00};
            stage_valid_reg    <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            write_started_reg  <= write_started_next;
            write_finished_reg <= write_finished_next;
            read_started_reg   <= read_started_next;
            read_finished_reg  <= read_finished_next;
            writer_half_reg    <= writer_half_next;
            length_reg         <= length_next;
            error_reg          <= error_next;
            xor_reg            <= xor_next;
            claimed_reg        <= claimed_next;
            last_reg           <= last_next;
            stage_valid_reg    <= stage_valid_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
        if (stage_move)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SEFR_ASSERT_SAME(a_stall_blocks_input, stage_valid_reg && result_valid_reg && !result_ready, !item_ready)
    `SEFR_ASSERT_NEXT(a_accept_fills_stage, item_valid && item_ready, stage_valid_reg)
    `SEFR_ASSERT_NEXT(a_swap_needs_transfer, !(item_valid && item_ready), $stable(writer_half_reg))
    `SEFR_ASSERT_SAME(a_finish_after_start, write_finished_reg, write_started_reg)
    `SEFR_ASSERT_SAME(a_written_not_opened, stage_valid_reg && stage_reg.frame_written, !stage_reg.frame_ready && !stage_reg.use_data)

endmodule

`default_nettype wire

// ===== dv/tb_stx_etx_frame_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stx_etx_frame_receiver
// self-checking bench for the stx/etx frame receiver: a directed table walks
// framing, swap and error cases, then random frames, reader sessions and
// noise run with random stalls on both sides; every result is compared with
// its table entry or a cycle-free prediction of the store and reader logic
// ----------------------------------------------------------------------------
module tb_stx_etx_frame_receiver
    import sefr_pkg::*;
();

    localparam int FRAME_DEPTH   = 256;
    localparam int HALF_SPAN     = 256;
    localparam int DIRECTED_ROWS = 26;
    localparam int ITEM_TARGET   = 1850;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;
    localparam result_t IDLE_RESULT = '0;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t want;
    } row_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_LEN,
        FR_SHORT,
        FR_TRUNC,
        FR_NO_LEN,
        FR_MAX
    } frame_kind_t;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // predicted frame control and per-half state
    logic       wr_open;
    logic       wr_done;
    logic       rd_open;
    logic       rd_done;
    logic       wr_half;
    logic [7:0] half_mem [2][HALF_SPAN];
    bit         mem_written [2][HALF_SPAN];
    logic [8:0] fill_len [2];
    logic       rx_err [2];
    logic [7:0] chk_xor [2];
    logic [7:0] len_field [2];
    logic [7:0] prev_byte [2];

    result_t frame_out_q [$];
    result_t oldest_res;
    row_t    stim_rows [DIRECTED_ROWS];
    int      items_sent = 0;
    int      results_seen = 0;
    int      fail_count = 0;
    int      cycle_count = 0;
    bit      gaps_off = 1'b0;
    bit      long_hold_done = 1'b0;

    stx_etx_frame_receiver uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void swap_if_reader_free();
        if ((rd_done || !rd_open) && wr_done)
        begin
            wr_open = 1'b0;
            wr_done = 1'b0;
            rd_open = 1'b0;
            rd_done = 1'b0;
            wr_half = ~wr_half;
        end
    endfunction

    function automatic void close_write();
        wr_done = 1'b1;
        swap_if_reader_free();
    endfunction

    function automatic logic store_rx_byte(logic [7:0] ch);
        logic       h;
        logic [8:0] size;
        logic [8:0] claimed;
        if (ch == STX_BYTE && (!wr_open || wr_done))
        begin
            swap_if_reader_free();
            wr_open = 1'b1;
            wr_done = 1'b0;
            fill_len[wr_half] = '0;
            rx_err[wr_half] = 1'b0;
            chk_xor[wr_half] = '0;
        end
        if (!wr_open)
            return 1'b0;
        if (wr_done)
        begin
            close_write();
            return 1'b0;
        end
        h = wr_half;
        size = fill_len[h];
        if (size >= FRAME_DEPTH)
        begin
            fill_len[h] = '0;
            rx_err[h] = 1'b1;
            close_write();
            return 1'b1;
        end
        claimed = (size >= 9'd2) ? {1'b0, len_field[h]} : 9'd0;
        if (claimed != 9'd0 && size >= claimed)
        begin
            rx_err[h] = 1'b1;
            fill_len[h] = '0;
            close_write();
            return 1'b1;
        end
        if (size >= ERROR_CLEAR_FROM)
            rx_err[h] = 1'b0;
        half_mem[h][size] = ch;
        mem_written[h][size] = 1'b1;
        if (size == 9'd1)
            len_field[h] = ch;
        chk_xor[h] = chk_xor[h] ^ ch;
        fill_len[h] = size + 9'd1;
        if (size >= 9'd2 && prev_byte[h] == ETX_BYTE && size + 9'd1 == claimed)
        begin
            prev_byte[h] = ch;
            close_write();
            return 1'b1;
        end
        prev_byte[h] = ch;
        return 1'b0;
    endfunction

    function automatic result_t frame_rx_step(item_t it);
        result_t    res;
        logic       rh;
        logic [8:0] stored;
        logic [8:0] pos;
        logic [1:0] code;
        res = '0;
        rh = ~wr_half;
        unique case (it.mode)
            MODE_BYTE:
                res.frame_written = store_rx_byte(it.rx_byte);
            MODE_OPEN:
            begin
                if (!rd_done)
                begin
                    stored = fill_len[rh];
                    rd_open = 1'b1;
                    if (rx_err[rh])
                        code = ERR_RECEIVE;
                    else if (stored < FRAME_OVERHEAD || stored > MAX_STORED ||
                             stored != {1'b0, len_field[rh]})
                        code = ERR_LENGTH;
                    else if (chk_xor[rh] != 8'h00)
                        code = ERR_CHECKSUM;
                    else
                        code = ERR_NONE;
                    if (code != ERR_NONE)
                        rd_done = 1'b1;
                    stored = stored - FRAME_OVERHEAD;
                    res.frame_ready = 1'b1;
                    res.frame_ok = (code == ERR_NONE);
                    res.error_code = code;
                    res.frame_id = half_mem[rh][ID_POS];
                    res.payload_length = stored[7:0];
                end
            end
            MODE_READ:
            begin
                pos = {1'b0, it.read_index} + PAYLOAD_POS;
                if (pos < FRAME_DEPTH)
                    res.read_data = half_mem[rh][pos];
            end
            default:
                rd_done = 1'b1;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (gaps_off)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] pick_read_index();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return 8'($urandom_range(253, 255));
        if (roll < 8)
            return 8'($urandom_range(0, 20));
        return 8'($urandom_range(0, 255));
    endfunction

    // reads of store entries never written are steered away
    task automatic send_item(item_t it, logic typed, result_t want);
        result_t predicted;
        logic    rh;
        int      pos;
        int      gap;
        rh = ~wr_half;
        pos = int'(it.read_index) + int'(PAYLOAD_POS);
        if (it.mode == MODE_OPEN && !rd_done && !mem_written[rh][ID_POS])
            it.mode = MODE_RELEASE;
        if (it.mode == MODE_READ && pos < FRAME_DEPTH && !mem_written[rh][pos])
            it.read_index = 8'hFF;
        predicted = frame_rx_step(it);
        frame_out_q.push_back(typed ? want : predicted);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic send_rx(logic [7:0] b);
        send_item({MODE_BYTE, b, 8'($urandom)}, 1'b0, IDLE_RESULT);
    endtask

    task automatic send_cmd(logic [1:0] m);
        send_item({m, 8'($urandom), pick_read_index()}, 1'b0, IDLE_RESULT);
    endtask

    task automatic send_frame(frame_kind_t kind);
        int         n;
        int         cut;
        int         i;
        logic [7:0] claim;
        logic [7:0] sum;
        logic [7:0] frame_bytes [$];
        if (kind == FR_MAX)
            n = 250;
        else if (kind == FR_NO_LEN)
            n = 254;
        else if ($urandom_range(0, 9) < 8)
            n = $urandom_range(0, 8);
        else
            n = $urandom_range(9, 24);
        claim = 8'(n + 5);
        if (kind == FR_NO_LEN)
            claim = 8'h00;
        if (kind == FR_BAD_LEN)
            claim = $urandom_range(0, 1) ? claim + 8'($urandom_range(1, 3))
                                         : claim - 8'($urandom_range(1, 2));
        if (kind == FR_SHORT)
            claim = 8'($urandom_range(1, 4));
        frame_bytes.push_back(STX_BYTE);
        frame_bytes.push_back(claim);
        frame_bytes.push_back(8'($urandom));
        for (i = 0; i < n; i++)
            frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(ETX_BYTE);
        sum = '0;
        foreach (frame_bytes[i])
            sum = sum ^ frame_bytes[i];
        if (kind == FR_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        cut = (kind == FR_TRUNC) ? $urandom_range(1, frame_bytes.size() - 1)
                                 : frame_bytes.size();
        for (i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_cmd(2'($urandom_range(1, 3)));
            send_rx(frame_bytes[i]);
        end
    endtask

    task automatic reader_session();
        int k;
        send_cmd(MODE_OPEN);
        if ($urandom_range(0, 9) == 0)
            send_cmd(MODE_OPEN);
        k = $urandom_range(0, 4);
        repeat (k) send_cmd(MODE_READ);
        if ($urandom_range(0, 9) < 8)
            send_cmd(MODE_RELEASE);
    endtask

    initial
    begin
        int          i;
        int          roll;
        int          j;
        bit          paused_once;
        frame_kind_t kind;
        paused_once = 1'b0;
        wr_open = 1'b0;
        wr_done = 1'b0;
        rd_open = 1'b1;
        rd_done = 1'b1;
        wr_half = 1'b0;
        for (i = 0; i < 2; i++)
        begin
            fill_len[i] = '0;
            rx_err[i] = 1'b0;
            chk_xor[i] = '0;
            len_field[i] = '0;
            prev_byte[i] = '0;
            for (j = 0; j < HALF_SPAN; j++)
                mem_written[i][j] = 1'b0;
        end
        stim_rows = '{
            {MODE_OPEN, 8'h00, 8'h00, 1'b1, IDLE_RESULT},
            {MODE_RELEASE, 8'h00, 8'h00, 1'b1, IDLE_RESULT},
            {MODE_BYTE, 8'hFF, 8'h00, 1'b1, IDLE_RESULT},
            {MODE_BYTE, STX_BYTE, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h06, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'hA5, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h5A, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, ETX_BYTE, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'hF8, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_OPEN, 8'h00, 8'h00, 1'b1,
             {1'b0, 1'b1, 1'b1, ERR_NONE, 8'hA5, 8'h01, 8'h00}},
            {MODE_READ, 8'h00, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_READ, 8'h00, 8'hFF, 1'b1, IDLE_RESULT},
            {MODE_BYTE, STX_BYTE, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h06, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h11, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h22, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, ETX_BYTE, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h00, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h7E, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_RELEASE, 8'h00, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h00, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_OPEN, 8'h00, 8'h00, 1'b1,
             {1'b0, 1'b1, 1'b0, ERR_CHECKSUM, 8'h11, 8'h01, 8'h00}},
            {MODE_BYTE, STX_BYTE, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, ETX_BYTE, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_BYTE, 8'h44, 8'h00, 1'b0, IDLE_RESULT},
            {MODE_OPEN, 8'h00, 8'h00, 1'b1,
             {1'b0, 1'b1, 1'b0, ERR_LENGTH, 8'h44, 8'hFE, 8'h00}}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < DIRECTED_ROWS; i++)
            send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);
        send_frame(FR_NO_LEN);
        reader_session();
        send_frame(FR_MAX);
        reader_session();
        while (items_sent < ITEM_TARGET)
        begin
            gaps_off = ($urandom_range(0, 9) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                j = $urandom_range(0, 99);
                if (j < 50)
                    kind = FR_GOOD;
                else if (j < 65)
                    kind = FR_BAD_SUM;
                else if (j < 77)
                    kind = FR_BAD_LEN;
                else if (j < 87)
                    kind = FR_SHORT;
                else if (j < 97)
                    kind = FR_TRUNC;
                else if (j < 98)
                    kind = FR_NO_LEN;
                else
                    kind = FR_MAX;
                send_frame(kind);
                if ($urandom_range(0, 9) < 6)
                    reader_session();
            end
            else if (roll < 75)
                reader_session();
            else if (roll < 85)
            begin
                repeat ($urandom_range(1, 4))
                    send_rx(($urandom_range(0, 4) == 0) ? STX_BYTE : 8'($urandom));
            end
            else
                send_cmd(2'($urandom_range(0, 3)));
            if (!paused_once && items_sent >= ITEM_TARGET / 2)
            begin
                item_valid <= 1'b0;
                while (frame_out_q.size() != 0)
                    @(posedge clk);
                paused_once = 1'b1;
            end
        end
        gaps_off = 1'b0;
        item_valid <= 1'b0;
        while (frame_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && frame_out_q.size() == 0)
            $display("stx_etx_frame_receiver test passed");
        else
            $display("stx_etx_frame_receiver test failed");
        $finish;
    end

    initial
    begin
        int stall;
        int run;
        int held;
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                result_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                long_hold_done = 1'b1;
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (frame_out_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result transfer %0d arrived with nothing expected",
                             results_seen);
            end
            else
            begin
                oldest_res = frame_out_q.pop_front();
                if (result.frame_written !== oldest_res.frame_written ||
                    result.frame_ready !== oldest_res.frame_ready ||
                    result.frame_ok !== oldest_res.frame_ok ||
                    result.error_code !== oldest_res.error_code ||
                    result.frame_id !== oldest_res.frame_id ||
                    result.payload_length !== oldest_res.payload_length ||
                    result.read_data !== oldest_res.read_data)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("result %0d: expected w%0b r%0b ok%0b err%0d id %h len %h data %h",
                                 results_seen, oldest_res.frame_written,
                                 oldest_res.frame_ready, oldest_res.frame_ok,
                                 oldest_res.error_code, oldest_res.frame_id,
                                 oldest_res.payload_length, oldest_res.read_data);
                        $display("result %0d: got      w%0b r%0b ok%0b err%0d id %h len %h data %h",
                                 results_seen, result.frame_written, result.frame_ready,
                                 result.frame_ok, result.error_code, result.frame_id,
                                 result.payload_length, result.read_data);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("stx_etx_frame_receiver test failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sefr_pkg.sv
hdl/sefr_store.sv
hdl/stx_etx_frame_receiver.sv
dv/tb_stx_etx_frame_receiver.sv
